@@ sv/lroc_pkg.sv @@
`default_nettype none

package lroc_pkg;

  // Sizes of the lock registry and of the per-task held-mask table.
  localparam int REGISTRY_DEPTH = 16;
  localparam int TASK_COUNT     = 16;

  // Fixed field widths.
  localparam int ADDR_W = 48;
  localparam int RANK_W = 16;
  localparam int TASK_W = 4;

  // Derived widths for the registry and the task table.
  localparam int COUNT_W     = $clog2(REGISTRY_DEPTH + 1);
  localparam int ENTRY_IDX_W = (REGISTRY_DEPTH > 1) ? $clog2(REGISTRY_DEPTH) : 1;
  localparam int TASK_IDX_W  = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int TASK_EXT_W  = (TASK_IDX_W > TASK_W) ? TASK_IDX_W : TASK_W;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_ARM      = 2'd1,
    CMD_ACQUIRE  = 2'd2,
    CMD_RELEASE  = 2'd3
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_IGNORED   = 2'd1,
    ST_VIOLATION = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Command word.
  typedef struct packed {
    cmd_t                cmd;
    logic [ADDR_W-1:0]   lock_address;
    logic [RANK_W-1:0]   rank;
    logic [TASK_W-1:0]   task_index;
    logic                task_valid;
  } item_t;

  // Result word.
  typedef struct packed {
    status_t             status;
    logic [RANK_W-1:0]   mask_after;
    logic [RANK_W-1:0]   found_rank;
  } result_t;

endpackage

`default_nettype wire

@@ sv/lroc_registry.sv @@
`default_nettype none

module lroc_registry (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       append,
  input  wire logic [lroc_pkg::ADDR_W-1:0] address,
  input  wire logic [lroc_pkg::RANK_W-1:0] new_rank,
  output logic                            full,
  output logic [lroc_pkg::RANK_W-1:0]     found_rank
);

  // Entries are written in order; only those below the fill count are live.
  logic [lroc_pkg::ADDR_W-1:0]  entry_addresses [lroc_pkg::REGISTRY_DEPTH];
  logic [lroc_pkg::RANK_W-1:0]  entry_ranks     [lroc_pkg::REGISTRY_DEPTH];
  logic [lroc_pkg::COUNT_W-1:0] entry_count;
  logic [lroc_pkg::REGISTRY_DEPTH-1:0] hit;

  assign full = (entry_count == lroc_pkg::COUNT_W'(lroc_pkg::REGISTRY_DEPTH));

  // Fill count, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (append && !full) begin
      entry_count <= entry_count + lroc_pkg::COUNT_W'(1);
    end
  end

  // Entry storage needs no reset: the fill count guards every read.
  always_ff @(posedge clk) begin
    if (append && !full) begin
      entry_addresses[entry_count[lroc_pkg::ENTRY_IDX_W-1:0]] <= address;
      entry_ranks[entry_count[lroc_pkg::ENTRY_IDX_W-1:0]]     <= new_rank;
    end
  end

  // Compare every live entry at once; the lowest matching entry wins.
  always_comb begin
    found_rank = '0;
    for (int i = 0; i < lroc_pkg::REGISTRY_DEPTH; i++) begin
      hit[i] = (lroc_pkg::COUNT_W'(i) < entry_count) && (entry_addresses[i] == address);
    end
    for (int i = lroc_pkg::REGISTRY_DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found_rank = entry_ranks[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/lock_rank_order_checker_unit.sv @@
`default_nettype none

// Channel   Handshake          Payload              Direction
// command   start / busy       item   (item_t)      in
// result    done (strobe)      result (result_t)    out
//
// A command word is taken at every edge with start high and busy low, so one
// word per cycle is sustained outside reset. The result passes through the
// input register, then through the registry compare and the held-mask update
// into the result register. busy is high only during reset.
// Reset clears the fill count, the armed flag and all held masks. The result
// is shown for one cycle with done and cannot be stalled.

module lock_rank_order_checker_unit (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire lroc_pkg::item_t  item,
  output logic                  done,
  output lroc_pkg::result_t     result
);

  // Input register.
  logic             item_valid;
  lroc_pkg::item_t  item_q;

  // Control state.
  logic                        armed;
  logic [lroc_pkg::RANK_W-1:0] held_masks [lroc_pkg::TASK_COUNT];

  // Working signals.
  logic                            reg_full;
  logic [lroc_pkg::RANK_W-1:0]     found;
  logic [lroc_pkg::TASK_EXT_W-1:0] task_ext;
  logic [lroc_pkg::TASK_IDX_W-1:0] task_idx;
  logic                            task_ok;
  logic [lroc_pkg::RANK_W-1:0]     mask_cur;
  logic [lroc_pkg::RANK_W-1:0]     mask_next;
  logic                            mask_we;
  logic                            armed_next;
  logic                            lookup_cmd;
  lroc_pkg::result_t               result_next;

  assign busy = rst;

  // Capture each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_q <= item;
    end
  end

  // Registry of lock addresses and their ranks.
  lroc_registry u_registry (
    .clk        (clk),
    .rst        (rst),
    .append     (item_valid && (item_q.cmd == lroc_pkg::CMD_REGISTER)),
    .address    (item_q.lock_address),
    .new_rank   (item_q.rank),
    .full       (reg_full),
    .found_rank (found)
  );

  // Task selection and range check.
  assign task_ext = lroc_pkg::TASK_EXT_W'(item_q.task_index);
  assign task_idx = task_ext[lroc_pkg::TASK_IDX_W-1:0];
  assign task_ok  = item_q.task_valid && (32'(item_q.task_index) < lroc_pkg::TASK_COUNT);
  assign mask_cur = held_masks[task_idx];
  assign lookup_cmd = (item_q.cmd == lroc_pkg::CMD_ACQUIRE) ||
                      (item_q.cmd == lroc_pkg::CMD_RELEASE);

  // Command decode, status and mask update.
  always_comb begin
    result_next.status = lroc_pkg::ST_DONE;
    result_next.found_rank = lookup_cmd ? found : '0;
    mask_next  = mask_cur;
    mask_we    = 1'b0;
    armed_next = armed;
    unique case (item_q.cmd)
      lroc_pkg::CMD_REGISTER: begin
        if (reg_full) begin
          result_next.status = lroc_pkg::ST_FULL;
        end
      end
      lroc_pkg::CMD_ARM: begin
        armed_next = 1'b1;
      end
      lroc_pkg::CMD_ACQUIRE: begin
        if (!armed || found == '0 || !task_ok) begin
          result_next.status = lroc_pkg::ST_IGNORED;
        end else begin
          if (mask_cur != '0 && !(mask_cur > found)) begin
            result_next.status = lroc_pkg::ST_VIOLATION;
          end
          mask_next = mask_cur | found;
          mask_we   = 1'b1;
        end
      end
      lroc_pkg::CMD_RELEASE: begin
        if (!armed || found == '0 || !task_ok) begin
          result_next.status = lroc_pkg::ST_IGNORED;
        end else begin
          mask_next = mask_cur & ~found;
          mask_we   = 1'b1;
        end
      end
      default: begin
        result_next.status = lroc_pkg::ST_IGNORED;
      end
    endcase
    result_next.mask_after = task_ok ? mask_next : '0;
  end

  // Armed flag and held masks.
  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
      for (int t = 0; t < lroc_pkg::TASK_COUNT; t++) begin
        held_masks[t] <= '0;
      end
    end else if (item_valid) begin
      armed <= armed_next;
      if (mask_we) begin
        held_masks[task_idx] <= mask_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/lroc_checker.sv @@
`default_nettype none

module lroc_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire lroc_pkg::result_t result
);

  // Every accepted word yields its result through the input and result registers.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted word gave no result");

  // No result appears without a matching accepted word.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a matching word");

  // A violation comes from a registered rank, whose bits are then held.
  a_violation_mask: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == lroc_pkg::ST_VIOLATION) |->
      (result.found_rank != '0) &&
      ((result.mask_after & result.found_rank) == result.found_rank))
    else $error("violation without held rank bits");

  // A full registry is only reported for a registration, which looks nothing up.
  a_full_no_rank: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == lroc_pkg::ST_FULL) |-> result.found_rank == '0)
    else $error("registry full with a found rank");

endmodule

bind lock_rank_order_checker_unit lroc_checker u_checker (.*);

`default_nettype wire
